>>> rtl/matrix_multiply_engine_top_macros.svh
// assertion macros shared by the engine modules
`ifndef MATRIX_MULTIPLY_ENGINE_TOP_MACROS_SVH
`define MATRIX_MULTIPLY_ENGINE_TOP_MACROS_SVH

// same-cycle implication
`define MME_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define MME_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/mme_pkg.sv
package mme_pkg;

   localparam int DIM_W           = 4;
   localparam int IDX_W           = 3;
   localparam int ELEM_W          = 16;
   localparam int RES_W           = 32;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 4;
   localparam int MAX_DIM_DEFAULT = 8;
   localparam int FLUSH_CYCLES    = 2;
   localparam int FLUSH_W         = (FLUSH_CYCLES > 1) ? $clog2(FLUSH_CYCLES) : 1;

   typedef enum logic [1:0] {
      CMD_LOAD_A = 2'd0,
      CMD_LOAD_B = 2'd1,
      CMD_START  = 2'd2
   } cmd_code_type;

   typedef enum logic [1:0] {
      REG_ROWS_A    = 2'd0,
      REG_INNER_DIM = 2'd1,
      REG_COLS_B    = 2'd2
   } csr_reg_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_FLUSH,
      ST_PUSH
   } state_type;

   // clamped dimensions
   typedef struct packed {
      logic [DIM_W-1:0] nr;
      logic [DIM_W-1:0] nk;
      logic [DIM_W-1:0] nc;
   } dims_type;

   typedef struct packed {
      logic             wr_a;
      logic             wr_b;
      logic             rd;
      logic             first;
      logic             push;
      logic             last;
      logic [IDX_W-1:0] i;
      logic [IDX_W-1:0] j;
      logic [IDX_W-1:0] k;
   } dp_cmd_type;

   typedef struct packed {
      logic out_free;
   } dp_status_type;

endpackage

>>> rtl/mme_req_if.sv
interface mme_req_if;
   logic                              valid;
   logic                              ready;
   logic [1:0]                        command;
   logic [mme_pkg::IDX_W-1:0]         row_index;
   logic [mme_pkg::IDX_W-1:0]         col_index;
   logic signed [mme_pkg::ELEM_W-1:0] element;

   modport source (output valid, output command, output row_index, output col_index,
                   output element, input ready);
   modport sink (input valid, input command, input row_index, input col_index,
                 input element, output ready);
endinterface

>>> rtl/mme_rsp_if.sv
interface mme_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mme_pkg::IDX_W-1:0]        out_row;
   logic [mme_pkg::IDX_W-1:0]        out_col;
   logic signed [mme_pkg::RES_W-1:0] product_value;
   logic                             saturated;
   logic                             last;

   modport source (output valid, output out_row, output out_col, output product_value,
                   output saturated, output last, input ready);
   modport sink (input valid, input out_row, input out_col, input product_value,
                 input saturated, input last, output ready);
endinterface

>>> rtl/mme_ram.sv
module mme_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64,
   parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/mme_csr.sv
module mme_csr #(
   parameter int MAX_DIM = mme_pkg::MAX_DIM_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [mme_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [mme_pkg::CSR_DATA_W-1:0]  pwdata,
   output logic [mme_pkg::CSR_DATA_W-1:0]  prdata,
   output mme_pkg::dims_type               dims
);

   localparam logic [mme_pkg::DIM_W-1:0] DIM_MAX   = mme_pkg::DIM_W'(MAX_DIM);
   localparam logic [mme_pkg::DIM_W-1:0] DIM_RESET = mme_pkg::DIM_W'(8);

   logic [mme_pkg::DIM_W-1:0] rows_a_ff, rows_a_in;
   logic [mme_pkg::DIM_W-1:0] inner_dim_ff, inner_dim_in;
   logic [mme_pkg::DIM_W-1:0] cols_b_ff, cols_b_in;
   logic                      wr_en;
   mme_pkg::csr_reg_type      reg_sel;

   function automatic logic [mme_pkg::DIM_W-1:0] clamp_dim(
      input logic [mme_pkg::DIM_W-1:0] v
   );
      logic [mme_pkg::DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = mme_pkg::DIM_W'(1);
      end else if (v > DIM_MAX) begin
         r = DIM_MAX;
      end
      return r;
   endfunction

   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = mme_pkg::csr_reg_type'(paddr[3:2]);

   always_comb begin
      rows_a_in    = rows_a_ff;
      inner_dim_in = inner_dim_ff;
      cols_b_in    = cols_b_ff;
      prdata       = '0;
      unique case (reg_sel)
         mme_pkg::REG_ROWS_A: begin
            rows_a_in = pwdata[mme_pkg::DIM_W-1:0];
            prdata    = mme_pkg::CSR_DATA_W'(rows_a_ff);
         end
         mme_pkg::REG_INNER_DIM: begin
            inner_dim_in = pwdata[mme_pkg::DIM_W-1:0];
            prdata       = mme_pkg::CSR_DATA_W'(inner_dim_ff);
         end
         mme_pkg::REG_COLS_B: begin
            cols_b_in = pwdata[mme_pkg::DIM_W-1:0];
            prdata    = mme_pkg::CSR_DATA_W'(cols_b_ff);
         end
         default: begin
            prdata = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff    <= DIM_RESET;
         inner_dim_ff <= DIM_RESET;
         cols_b_ff    <= DIM_RESET;
      end else if (wr_en) begin
         rows_a_ff    <= rows_a_in;
         inner_dim_ff <= inner_dim_in;
         cols_b_ff    <= cols_b_in;
      end
   end

   assign dims.nr = clamp_dim(rows_a_ff);
   assign dims.nk = clamp_dim(inner_dim_ff);
   assign dims.nc = clamp_dim(cols_b_ff);

endmodule

>>> rtl/mme_datapath.sv
`include "matrix_multiply_engine_top_macros.svh"

module mme_datapath #(
   parameter int MAX_DIM = mme_pkg::MAX_DIM_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  mme_pkg::dp_cmd_type               cmd,
   input  logic [mme_pkg::IDX_W-1:0]         wr_row,
   input  logic [mme_pkg::IDX_W-1:0]         wr_col,
   input  logic signed [mme_pkg::ELEM_W-1:0] wr_element,
   output mme_pkg::dp_status_type            status,
   mme_rsp_if.source                         rsp
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int PROD_W = 2 * mme_pkg::ELEM_W;
   localparam int ACC_W  = mme_pkg::RES_W + 1 + ((MAX_DIM > 1) ? $clog2(MAX_DIM) : 0);
   localparam int RES_W  = mme_pkg::RES_W;

   logic [AW-1:0]                 wr_addr;
   logic [AW-1:0]                 a_addr;
   logic [AW-1:0]                 b_addr;
   logic [mme_pkg::ELEM_W-1:0]    a_data;
   logic [mme_pkg::ELEM_W-1:0]    b_data;

   logic                          s1_valid_ff;
   logic                          s1_first_ff;
   logic                          s2_valid_ff;
   logic                          s2_first_ff;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;

   logic                          out_valid_ff;
   logic [mme_pkg::IDX_W-1:0]     out_row_ff;
   logic [mme_pkg::IDX_W-1:0]     out_col_ff;
   logic [RES_W-1:0]              out_value_ff, out_value_in;
   logic                          out_sat_ff, out_sat_in;
   logic                          out_last_ff;
   logic [ACC_W-RES_W:0]          acc_upper;

   assign wr_addr = AW'(int'(wr_row) * MAX_DIM + int'(wr_col));
   assign a_addr  = AW'(int'(cmd.i) * MAX_DIM + int'(cmd.k));
   assign b_addr  = AW'(int'(cmd.k) * MAX_DIM + int'(cmd.j));

   mme_ram #(.WIDTH(mme_pkg::ELEM_W), .DEPTH(DEPTH), .AW(AW)) u_store_a (
      .clock   (clock),
      .wr_en   (cmd.wr_a),
      .wr_addr (wr_addr),
      .wr_data (wr_element),
      .rd_en   (cmd.rd),
      .rd_addr (a_addr),
      .rd_data (a_data)
   );

   mme_ram #(.WIDTH(mme_pkg::ELEM_W), .DEPTH(DEPTH), .AW(AW)) u_store_b (
      .clock   (clock),
      .wr_en   (cmd.wr_b),
      .wr_addr (wr_addr),
      .wr_data (wr_element),
      .rd_en   (cmd.rd),
      .rd_addr (b_addr),
      .rd_data (b_data)
   );

   // multiply and accumulate
   assign prod_in = $signed(a_data) * $signed(b_data);

   always_comb begin
      acc_in = acc_ff;
      if (s2_valid_ff) begin
         if (s2_first_ff) begin
            acc_in = ACC_W'(prod_ff);
         end else begin
            acc_in = acc_ff + ACC_W'(prod_ff);
         end
      end
   end

   // saturate to the result width
   assign acc_upper = acc_ff[ACC_W-1:RES_W-1];

   always_comb begin
      out_sat_in   = !((&acc_upper) || (~|acc_upper));
      out_value_in = acc_ff[RES_W-1:0];
      if (out_sat_in) begin
         out_value_in = acc_ff[ACC_W-1] ? {1'b1, {(RES_W-1){1'b0}}}
                                        : {1'b0, {(RES_W-1){1'b1}}};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= cmd.rd;
         s2_valid_ff <= s1_valid_ff;
         if (cmd.push) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      s1_first_ff <= cmd.first;
      s2_first_ff <= s1_first_ff;
      prod_ff     <= prod_in;
      acc_ff      <= acc_in;
      if (cmd.push) begin
         out_row_ff   <= cmd.i;
         out_col_ff   <= cmd.j;
         out_value_ff <= out_value_in;
         out_sat_ff   <= out_sat_in;
         out_last_ff  <= cmd.last;
      end
   end

   assign status.out_free   = !out_valid_ff || rsp.ready;

   assign rsp.valid         = out_valid_ff;
   assign rsp.out_row       = out_row_ff;
   assign rsp.out_col       = out_col_ff;
   assign rsp.product_value = out_value_ff;
   assign rsp.saturated     = out_sat_ff;
   assign rsp.last          = out_last_ff;

   `MME_ASSERT_IMPLY(a_pipe_drained_at_push, clock, reset, cmd.push, !s1_valid_ff && !s2_valid_ff, "accumulator pushed while terms in flight")
   `MME_ASSERT_NEXT(a_push_fills_output, clock, reset, cmd.push, out_valid_ff, "pushed result not held in output register")

endmodule

>>> rtl/mme_ctrl.sv
`include "matrix_multiply_engine_top_macros.svh"

module mme_ctrl (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic [1:0]                   req_command,
   input  logic [mme_pkg::IDX_W-1:0]    req_row,
   input  logic [mme_pkg::IDX_W-1:0]    req_col,
   output logic                         req_ready,
   input  mme_pkg::dims_type            dims,
   input  mme_pkg::dp_status_type       status,
   output mme_pkg::dp_cmd_type          cmd
);

   localparam int DIM_W = mme_pkg::DIM_W;

   mme_pkg::state_type              state_ff, state_in;
   logic [mme_pkg::IDX_W-1:0]       i_ff, i_in;
   logic [mme_pkg::IDX_W-1:0]       j_ff, j_in;
   logic [mme_pkg::IDX_W-1:0]       k_ff, k_in;
   logic [mme_pkg::FLUSH_W-1:0]     flush_ff, flush_in;
   logic                            i_last;
   logic                            j_last;
   logic                            k_last;
   logic                            elem_last;
   logic                            a_in_range;
   logic                            b_in_range;

   assign i_last    = (DIM_W'(i_ff) + DIM_W'(1)) == dims.nr;
   assign j_last    = (DIM_W'(j_ff) + DIM_W'(1)) == dims.nc;
   assign k_last    = (DIM_W'(k_ff) + DIM_W'(1)) == dims.nk;
   assign elem_last = i_last && j_last;

   assign a_in_range = (DIM_W'(req_row) < dims.nr) && (DIM_W'(req_col) < dims.nk);
   assign b_in_range = (DIM_W'(req_row) < dims.nk) && (DIM_W'(req_col) < dims.nc);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mme_pkg::ST_IDLE: begin
            if (req_valid && (req_command == mme_pkg::CMD_START)) begin
               state_in = mme_pkg::ST_ISSUE;
            end
         end
         mme_pkg::ST_ISSUE: begin
            if (k_last) begin
               state_in = mme_pkg::ST_FLUSH;
            end
         end
         mme_pkg::ST_FLUSH: begin
            if (flush_ff == '0) begin
               state_in = mme_pkg::ST_PUSH;
            end
         end
         mme_pkg::ST_PUSH: begin
            if (status.out_free) begin
               state_in = elem_last ? mme_pkg::ST_IDLE : mme_pkg::ST_ISSUE;
            end
         end
         default: begin
            state_in = mme_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready = 1'b0;
      cmd       = '0;
      cmd.i     = i_ff;
      cmd.j     = j_ff;
      cmd.k     = k_ff;
      cmd.last  = elem_last;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;
      flush_in  = flush_ff;
      unique case (state_ff)
         mme_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_command)
                  mme_pkg::CMD_LOAD_A: begin
                     cmd.wr_a = a_in_range;
                  end
                  mme_pkg::CMD_LOAD_B: begin
                     cmd.wr_b = b_in_range;
                  end
                  mme_pkg::CMD_START: begin
                     i_in = '0;
                     j_in = '0;
                     k_in = '0;
                  end
                  default: begin
                     cmd.wr_a = 1'b0;
                  end
               endcase
            end
         end
         mme_pkg::ST_ISSUE: begin
            cmd.rd    = 1'b1;
            cmd.first = (k_ff == '0);
            if (k_last) begin
               k_in     = '0;
               flush_in = mme_pkg::FLUSH_W'(mme_pkg::FLUSH_CYCLES - 1);
            end else begin
               k_in = k_ff + 1'b1;
            end
         end
         mme_pkg::ST_FLUSH: begin
            flush_in = flush_ff - 1'b1;
         end
         mme_pkg::ST_PUSH: begin
            if (status.out_free) begin
               cmd.push = 1'b1;
               if (j_last) begin
                  j_in = '0;
                  i_in = i_ff + 1'b1;
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mme_pkg::ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
         flush_ff <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
         flush_ff <= flush_in;
      end
   end

   `MME_ASSERT_IMPLY(a_push_needs_free, clock, reset, cmd.push, status.out_free, "result pushed into a full output register")
   `MME_ASSERT_NEXT(a_last_returns_idle, clock, reset, cmd.push && cmd.last, req_ready, "run did not end after its last element")
   `MME_ASSERT_IMPLY(a_read_inside_dims, clock, reset, cmd.rd, (DIM_W'(cmd.k) < dims.nk) && (DIM_W'(cmd.i) < dims.nr) && (DIM_W'(cmd.j) < dims.nc), "read index outside dimensions")

endmodule

>>> rtl/matrix_multiply_engine_top.sv
// matrix multiply engine, signed Q8.8 elements, saturated Q16.16 results
// req channel: command load A (0), load B (1) or start (2), with row, column, element.
//   loads take one request per cycle while idle; a load outside the current dimensions is dropped.
// rsp channel: one result per product element, row-major, last set on the final one.
// csr port: rows_a at 0x0, inner_dim at 0x4, cols_b at 0x8, 4 bits each, reset 8;
//   0 acts as 1 and values above MAX_DIM as MAX_DIM in use. write only while idle.
// a start run works out one result at a time with the single multiply-accumulate unit,
//   which reads one A and one B entry per cycle from the two element rams, then drains
//   the multiply and accumulate stages in the flush state, and pushes the result.
// req ready is low from the start request until the last result sits in the output
//   register; loads are then taken while that result waits.
// rsp stall: a result stays in the output register until it is taken; the run holds before its next push.
// reset: dimensions return to 8, output empties, ram contents stay undefined until loaded.
module matrix_multiply_engine_top #(
   parameter int MAX_DIM = mme_pkg::MAX_DIM_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   mme_req_if.sink                        req,
   mme_rsp_if.source                      rsp,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [mme_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [mme_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [mme_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);

   mme_pkg::dims_type      dims;
   mme_pkg::dp_cmd_type    cmd;
   mme_pkg::dp_status_type status;
   logic                   ready;

   assign csr_pready = 1'b1;
   assign req.ready  = ready;

   mme_csr #(.MAX_DIM(MAX_DIM)) u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .dims    (dims)
   );

   mme_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req.valid),
      .req_command (req.command),
      .req_row     (req.row_index),
      .req_col     (req.col_index),
      .req_ready   (ready),
      .dims        (dims),
      .status      (status),
      .cmd         (cmd)
   );

   mme_datapath #(.MAX_DIM(MAX_DIM)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .wr_row     (req.row_index),
      .wr_col     (req.col_index),
      .wr_element (req.element),
      .status     (status),
      .rsp        (rsp)
   );

endmodule

>>> test/matrix_multiply_engine_top_tb.sv
`timescale 1ns / 1ps

module matrix_multiply_engine_top_tb;

   localparam int DIM_MAX        = mme_pkg::MAX_DIM_DEFAULT;
   localparam int ITEM_TARGET    = 430;
   localparam int IDLE_PCT       = 15;
   localparam int SETTLE_CYCLES  = 16;
   localparam int HOLD_CYCLES    = 400;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam logic [1:0] CMD_UNUSED = 2'd3;
   localparam longint SUM_MAX = 64'sd2147483647;
   localparam longint SUM_MIN = -64'sd2147483648;

   typedef struct {
      logic [1:0]        cmd;
      logic [2:0]        row;
      logic [2:0]        col;
      logic signed [15:0] value;
   } matrix_cmd_type;

   typedef struct packed {
      logic [2:0]         row;
      logic [2:0]         col;
      logic signed [31:0] value;
      logic               sat;
      logic               last;
   } product_type;

   logic clock;
   logic reset;
   logic csr_psel;
   logic csr_penable;
   logic csr_pwrite;
   logic [mme_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [mme_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [mme_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   mme_req_if req_bus();
   mme_rsp_if rsp_bus();

   matrix_multiply_engine_top u_top (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // predictor state
   logic [3:0]         rows_raw = 4'd8;
   logic [3:0]         inner_raw = 4'd8;
   logic [3:0]         cols_raw = 4'd8;
   logic signed [15:0] a_elems [DIM_MAX*DIM_MAX];
   logic signed [15:0] b_elems [DIM_MAX*DIM_MAX];
   product_type        due_products [$];

   // stimulus side
   matrix_cmd_type cmd_backlog [$];
   bit          filled_a [DIM_MAX*DIM_MAX];
   bit          filled_b [DIM_MAX*DIM_MAX];
   bit          calm = 1'b0;
   bit          heavy_elements = 1'b0;
   int          cmds_queued = 0;
   int          cmds_taken = 0;
   int          stim_items = 0;
   int          hold_asks = 0;
   int          hold_grants = 0;
   int          hold_left = 0;

   int mismatches = 0;
   int products_seen = 0;
   int sat_seen = 0;
   int starts_taken = 0;
   int dropped = 0;
   int csr_writes = 0;
   int phase_no = 0;
   int quiet_cycles = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic int clamp_dim(logic [3:0] raw);
      if (raw == 4'd0) return 1;
      if (raw > DIM_MAX) return DIM_MAX;
      return int'(raw);
   endfunction

   task automatic matmul_step(logic [1:0] cmd, logic [2:0] r, logic [2:0] c,
                              logic signed [15:0] v);
      int nr;
      int nk;
      int nc;
      longint acc;
      product_type p;
      nr = clamp_dim(rows_raw);
      nk = clamp_dim(inner_raw);
      nc = clamp_dim(cols_raw);
      if (cmd == mme_pkg::CMD_LOAD_A) begin
         if (r < nr && c < nk) a_elems[r * DIM_MAX + c] = v;
         else dropped++;
      end else if (cmd == mme_pkg::CMD_LOAD_B) begin
         if (r < nk && c < nc) b_elems[r * DIM_MAX + c] = v;
         else dropped++;
      end else if (cmd == mme_pkg::CMD_START) begin
         starts_taken++;
         for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
               acc = 0;
               for (int k = 0; k < nk; k++)
                  acc += longint'(a_elems[i * DIM_MAX + k]) * longint'(b_elems[k * DIM_MAX + j]);
               p.sat = 1'b0;
               if (acc > SUM_MAX) begin
                  acc = SUM_MAX;
                  p.sat = 1'b1;
               end else if (acc < SUM_MIN) begin
                  acc = SUM_MIN;
                  p.sat = 1'b1;
               end
               p.row = 3'(i);
               p.col = 3'(j);
               p.value = 32'(acc);
               p.last = (i == nr - 1) && (j == nc - 1);
               due_products.push_back(p);
            end
         end
      end else begin
         dropped++;
      end
   endtask

   // request driver
   always @(posedge clock) begin
      matrix_cmd_type cmd_item;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            matmul_step(req_bus.command, req_bus.row_index, req_bus.col_index, req_bus.element);
            cmds_taken++;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (cmd_backlog.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               cmd_item = cmd_backlog.pop_front();
               req_bus.valid     <= 1'b1;
               req_bus.command   <= cmd_item.cmd;
               req_bus.row_index <= cmd_item.row;
               req_bus.col_index <= cmd_item.col;
               req_bus.element   <= cmd_item.value;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // result ready, with long hold-offs on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_bus.ready <= 1'b0;
      end else if (hold_asks != hold_grants) begin
         hold_grants++;
         hold_left = HOLD_CYCLES;
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
      end
   end

   function automatic void check_field(string name, logic signed [63:0] want,
                                       logic signed [63:0] got);
      if (got !== want) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch on %s: expected %0d, got %0d", name, want, got);
      end
   endfunction

   // result checker
   always @(posedge clock) begin
      product_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         products_seen++;
         if (due_products.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected product row %0d col %0d value %0d",
                        rsp_bus.out_row, rsp_bus.out_col, rsp_bus.product_value);
         end else begin
            want = due_products.pop_front();
            if (want.sat) sat_seen++;
            check_field("out_row", want.row, rsp_bus.out_row);
            check_field("out_col", want.col, rsp_bus.out_col);
            check_field("product_value", want.value, rsp_bus.product_value);
            check_field("saturated", want.sat, rsp_bus.saturated);
            check_field("last", want.last, rsp_bus.last);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog expired after %0d cycles with no traffic", quiet_cycles);
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic write_csr(mme_pkg::csr_reg_type idx, logic [3:0] value);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= mme_pkg::CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         mme_pkg::REG_ROWS_A:    rows_raw = value;
         mme_pkg::REG_INNER_DIM: inner_raw = value;
         default:                cols_raw = value;
      endcase
      csr_writes++;
   endtask

   task automatic set_dims(logic [3:0] r, logic [3:0] k, logic [3:0] c);
      write_csr(mme_pkg::REG_ROWS_A, r);
      write_csr(mme_pkg::REG_INNER_DIM, k);
      write_csr(mme_pkg::REG_COLS_B, c);
   endtask

   function automatic logic [3:0] pick_dim_raw();
      int sel;
      sel = $urandom_range(0, 15);
      if (sel == 0) return 4'd0;
      if (sel == 1) return 4'($urandom_range(9, 15));
      if (sel <= 3) return 4'd8;
      return 4'($urandom_range(1, 4));
   endfunction

   function automatic logic signed [15:0] pick_element();
      int sel;
      sel = $urandom_range(0, 99);
      if (heavy_elements && sel < 60) return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      if (sel < 15) begin
         case ($urandom_range(0, 5))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return 16'sh0000;
            3:       return 16'shffff;
            4:       return 16'sh0100;
            default: return 16'shff00;
         endcase
      end
      return 16'($urandom_range(0, 65535));
   endfunction

   task automatic queue_request(logic [1:0] cmd, int r, int c, logic signed [15:0] v);
      matrix_cmd_type item;
      bit takes;
      int nr;
      int nk;
      int nc;
      nr = clamp_dim(rows_raw);
      nk = clamp_dim(inner_raw);
      nc = clamp_dim(cols_raw);
      takes = 1'b0;
      if (cmd == mme_pkg::CMD_LOAD_A && r < nr && c < nk) begin
         filled_a[r * DIM_MAX + c] = 1'b1;
         takes = 1'b1;
      end else if (cmd == mme_pkg::CMD_LOAD_B && r < nk && c < nc) begin
         filled_b[r * DIM_MAX + c] = 1'b1;
         takes = 1'b1;
      end else if (cmd == mme_pkg::CMD_START) begin
         takes = 1'b1;
      end
      item.cmd = cmd;
      item.row = 3'(r);
      item.col = 3'(c);
      item.value = v;
      cmd_backlog.push_back(item);
      cmds_queued++;
      if (takes) stim_items++;
   endtask

   // loads anything the product would read that was never written, then starts
   task automatic queue_start();
      int nr;
      int nk;
      int nc;
      nr = clamp_dim(rows_raw);
      nk = clamp_dim(inner_raw);
      nc = clamp_dim(cols_raw);
      for (int i = 0; i < nr; i++)
         for (int k = 0; k < nk; k++)
            if (!filled_a[i * DIM_MAX + k])
               queue_request(mme_pkg::CMD_LOAD_A, i, k, pick_element());
      for (int k = 0; k < nk; k++)
         for (int j = 0; j < nc; j++)
            if (!filled_b[k * DIM_MAX + j])
               queue_request(mme_pkg::CMD_LOAD_B, k, j, pick_element());
      queue_request(mme_pkg::CMD_START, $urandom_range(0, 7), $urandom_range(0, 7),
                    16'($urandom_range(0, 65535)));
   endtask

   task automatic queue_matrix_loads(int density);
      matrix_cmd_type batch [$];
      matrix_cmd_type tmp;
      int nr;
      int nk;
      int nc;
      int j;
      nr = clamp_dim(rows_raw);
      nk = clamp_dim(inner_raw);
      nc = clamp_dim(cols_raw);
      for (int r = 0; r < nr; r++)
         for (int c = 0; c < nk; c++)
            if (!filled_a[r * DIM_MAX + c] || $urandom_range(0, 99) < density)
               batch.push_back('{mme_pkg::CMD_LOAD_A, 3'(r), 3'(c), pick_element()});
      for (int r = 0; r < nk; r++)
         for (int c = 0; c < nc; c++)
            if (!filled_b[r * DIM_MAX + c] || $urandom_range(0, 99) < density)
               batch.push_back('{mme_pkg::CMD_LOAD_B, 3'(r), 3'(c), pick_element()});
      // noise: unused command and loads with arbitrary indices
      repeat ($urandom_range(0, 3)) begin
         case ($urandom_range(0, 2))
            0:       tmp.cmd = CMD_UNUSED;
            1:       tmp.cmd = mme_pkg::CMD_LOAD_A;
            default: tmp.cmd = mme_pkg::CMD_LOAD_B;
         endcase
         tmp.row = 3'($urandom_range(0, 7));
         tmp.col = 3'($urandom_range(0, 7));
         tmp.value = pick_element();
         batch.push_back(tmp);
      end
      for (int n = batch.size() - 1; n > 0; n--) begin
         j = $urandom_range(0, n);
         tmp = batch[n];
         batch[n] = batch[j];
         batch[j] = tmp;
      end
      foreach (batch[n])
         queue_request(batch[n].cmd, batch[n].row, batch[n].col, batch[n].value);
   endtask

   task automatic wait_drained();
      while (cmds_taken != cmds_queued || due_products.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.command = mme_pkg::CMD_LOAD_A;
      req_bus.row_index = '0;
      req_bus.col_index = '0;
      req_bus.element = '0;
      rsp_bus.ready = 1'b0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      foreach (a_elems[n]) a_elems[n] = '0;
      foreach (b_elems[n]) b_elems[n] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // 2x2x2 with full-scale values, positive overflow on the first product
      set_dims(4'd2, 4'd2, 4'd2);
      queue_request(mme_pkg::CMD_LOAD_A, 0, 0, 16'sh8000);
      queue_request(mme_pkg::CMD_LOAD_A, 0, 1, 16'sh8000);
      queue_request(mme_pkg::CMD_LOAD_A, 1, 0, 16'sh7fff);
      queue_request(mme_pkg::CMD_LOAD_A, 1, 1, 16'sh0001);
      queue_request(mme_pkg::CMD_LOAD_B, 0, 0, 16'sh8000);
      queue_request(mme_pkg::CMD_LOAD_B, 0, 1, 16'sh7fff);
      queue_request(mme_pkg::CMD_LOAD_B, 1, 0, 16'sh8000);
      queue_request(mme_pkg::CMD_LOAD_B, 1, 1, 16'sh0000);
      queue_request(mme_pkg::CMD_LOAD_A, 2, 0, 16'sh1234);
      queue_request(mme_pkg::CMD_LOAD_B, 1, 7, 16'shffff);
      queue_request(CMD_UNUSED, 7, 7, 16'sh7fff);
      queue_start();
      queue_start();
      wait_drained();

      // single product over three terms, negative overflow
      set_dims(4'd1, 4'd3, 4'd1);
      queue_request(mme_pkg::CMD_LOAD_A, 0, 2, 16'sh8000);
      queue_request(mme_pkg::CMD_LOAD_B, 0, 0, 16'sh7fff);
      queue_request(mme_pkg::CMD_LOAD_B, 1, 0, 16'sh7fff);
      queue_request(mme_pkg::CMD_LOAD_B, 2, 0, 16'sh7fff);
      queue_start();
      wait_drained();

      while (stim_items < ITEM_TARGET) begin
         calm = (phase_no == 4 || phase_no == 5);
         heavy_elements = ($urandom_range(0, 3) == 0);
         if (phase_no == 0) set_dims(4'd0, 4'd15, 4'd8);
         else if (phase_no == 1) set_dims(4'd9, 4'd8, 4'd0);
         else if (phase_no == 3) set_dims(4'd3, 4'd3, 4'd3);
         else if ($urandom_range(0, 99) < 40) set_dims(pick_dim_raw(), pick_dim_raw(), pick_dim_raw());
         if (phase_no == 3) begin
            queue_matrix_loads(100);
            queue_start();
            hold_asks++;
            queue_matrix_loads(100);
            queue_start();
         end else begin
            case ($urandom_range(0, 19))
               0, 1, 2: queue_matrix_loads(40);
               3, 4, 5: begin
                  queue_start();
                  queue_matrix_loads(20);
                  queue_start();
               end
               default: begin
                  queue_matrix_loads(30);
                  queue_start();
                  if ($urandom_range(0, 3) == 0) queue_start();
               end
            endcase
         end
         wait_drained();
         phase_no++;
      end

      wait_drained();
      if (due_products.size() != 0) begin
         $display("%0d products never arrived", due_products.size());
         mismatches += due_products.size();
      end
      $display("covered %0d requests: %0d starts, %0d dropped loads or unused commands",
               cmds_taken, starts_taken, dropped);
      $display("checked %0d products (%0d saturated) over %0d register writes in %0d phases",
               products_seen, sat_seen, csr_writes, phase_no + 2);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
